// ===== sv/plcf_pkg.sv =====
// Shared types, codes and helpers for the peer link connection manager.
// Used by every module of the block; depends on nothing else.
package plcf_pkg;

   localparam logic [2:0] KIND_TICK      = 3'd0;
   localparam logic [2:0] KIND_CONNECT   = 3'd1;
   localparam logic [2:0] KIND_REPORT    = 3'd2;
   localparam logic [2:0] KIND_STUN      = 3'd3;
   localparam logic [2:0] KIND_HEARTBEAT = 3'd4;

   localparam logic [2:0] ACT_STATUS     = 3'd0;
   localparam logic [2:0] ACT_HEARTBEAT  = 3'd1;
   localparam logic [2:0] ACT_PROBE      = 3'd2;
   localparam logic [2:0] ACT_ADDR_REP   = 3'd3;
   localparam logic [2:0] ACT_ROUTE_RST  = 3'd4;
   localparam logic [2:0] ACT_STUN_REQ   = 3'd5;

   localparam logic [2:0] MODE_INIT = 3'd0;
   localparam logic [2:0] MODE_PREP = 3'd1;
   localparam logic [2:0] MODE_SYNC = 3'd2;
   localparam logic [2:0] MODE_CONN = 3'd3;
   localparam logic [2:0] MODE_UP   = 3'd4;
   localparam logic [2:0] MODE_WAIT = 3'd5;
   localparam logic [2:0] MODE_FAIL = 3'd6;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_STUN_EN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RELAY_EN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCAL_DIS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_MIN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_MAX  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HS_TIMEOUT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ALIVE_TO   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_PROBE_PER  = 3'd7;

   localparam logic [31:0] RETRY_MIN_RESET = 32'd30000;
   localparam logic [31:0] RETRY_MAX_RESET = 32'd3600000;
   localparam logic [31:0] HS_TIMEOUT_RESET = 32'd10000;
   localparam logic [31:0] ALIVE_TO_RESET = 32'd3000;
   localparam logic [15:0] PROBE_PER_RESET = 16'd60;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] now_ms;
      logic [31:0] peer_ip;
      logic [15:0] peer_port;
      logic        report_is_local;
      logic        heartbeat_ack;
   } req_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] dest_ip;
      logic [15:0] dest_port;
      logic        report_local_flag;
      logic        ack_bit;
      logic [2:0]  link_state;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] ip;
      logic [15:0] port;
   } ep_type;

   typedef struct packed {
      logic is_tick;
      logic is_connect;
      logic is_report;
      logic is_stun;
      logic is_heartbeat;
   } class_type;

   typedef struct packed {
      req_type   req;
      class_type cls;
      logic      priv;
   } evt_type;

   typedef struct packed {
      logic        stun_enabled;
      logic        relay_enabled;
      logic        local_p2p_disabled;
      logic [31:0] retry_min_ms;
      logic [31:0] retry_max_ms;
      logic [31:0] handshake_timeout_ms;
      logic [31:0] alive_timeout_ms;
      logic [15:0] probe_period_ticks;
   } cfg_type;

   function automatic logic is_private(input logic [31:0] ip);
      logic [7:0] a;
      logic [7:0] b;
      a = ip[31:24];
      b = ip[23:16];
      return (a == 8'd10) || (a == 8'd172 && b[7:4] == 4'd1) ||
             (a == 8'd192 && b == 8'd168) || (a == 8'd169 && b == 8'd254) ||
             (a == 8'd239 && b == 8'd255);
   endfunction

endpackage

// ===== sv/plcf_front.sv =====
// Front part: decodes each incoming event and holds it in a two-entry queue.
// Depends on plcf_pkg.
module plcf_front import plcf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    evt_valid,
   output evt_type evt_data,
   input  logic    evt_take
);

   evt_type    q_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   evt_type    evt_new;
   logic       push_ok;

   always_comb begin
      evt_new.req = req_data;
      evt_new.priv = is_private(req_data.peer_ip);
      evt_new.cls = '0;
      unique case (req_data.kind)
         KIND_TICK:      evt_new.cls.is_tick = 1'b1;
         KIND_CONNECT:   evt_new.cls.is_connect = 1'b1;
         KIND_REPORT:    evt_new.cls.is_report = 1'b1;
         KIND_STUN:      evt_new.cls.is_stun = 1'b1;
         KIND_HEARTBEAT: evt_new.cls.is_heartbeat = 1'b1;
         default:        evt_new.cls = '0;
      endcase
   end

   assign req_full  = (cnt_ff == 2'd2);
   assign push_ok   = req_push && !req_full;
   assign evt_valid = (cnt_ff != 2'd0);
   assign evt_data  = q_ff[rd_ff];

   always_comb begin
      wr_in  = push_ok ? !wr_ff : wr_ff;
      rd_in  = evt_take ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push_ok} - {1'b0, evt_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ff] <= evt_new;
      end
   end

endmodule

// ===== sv/plcf_back.sv =====
// Back part: connection state, event handling and the result beat buffer.
// Depends on plcf_pkg; fed by plcf_front.
module plcf_back import plcf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    evt_valid,
   input  evt_type evt_data,
   output logic    evt_take,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic [2:0]  mode_ff, mode_in;
   logic [31:0] last_ff, last_in;
   logic [31:0] retry_ff, retry_in;
   logic [15:0] phase_ff, phase_in;
   ep_type      wide_ff, wide_in;
   ep_type      loc_ff, loc_in;
   ep_type      real_ff, real_in;
   logic        ack_ff, ack_in;

   rsp_type     item_ff [3];
   rsp_type     item_in [3];
   logic [1:0]  head_ff, head_in;
   logic [1:0]  cnt_ff, cnt_in;

   function automatic rsp_type make_item(input logic [2:0] act, input ep_type ep,
                                         input logic rlocal, input logic ack);
      rsp_type r;
      r.action = act;
      r.dest_ip = ep.ip;
      r.dest_port = ep.port;
      r.report_local_flag = rlocal;
      r.ack_bit = ack;
      r.link_state = MODE_INIT;
      r.last = 1'b0;
      return r;
   endfunction

   always_comb begin
      req_type     rq;
      ep_type      ep_new;
      ep_type      ep_none;
      rsp_type     c0, c1, st;
      logic        c0_v, c1_v;
      logic        set_req;
      logic [2:0]  set_tgt;
      logic [31:0] limit;
      logic        is_active;
      logic [16:0] phase_inc;
      logic [32:0] doubled;

      rq = evt_data.req;
      ep_new.valid = 1'b1;
      ep_new.ip = rq.peer_ip;
      ep_new.port = rq.peer_port;
      ep_none = '0;
      phase_inc = '0;

      mode_in = mode_ff;
      last_in = last_ff;
      retry_in = retry_ff;
      phase_in = phase_ff;
      wide_in = wide_ff;
      loc_in = loc_ff;
      real_in = real_ff;
      ack_in = ack_ff;
      c0 = make_item(ACT_STATUS, ep_none, 1'b0, 1'b0);
      c1 = c0;
      c0_v = 1'b0;
      c1_v = 1'b0;
      set_req = 1'b0;
      set_tgt = mode_ff;

      unique case (mode_ff)
         MODE_UP:   limit = cfg.alive_timeout_ms;
         MODE_WAIT: limit = retry_ff;
         default:   limit = cfg.handshake_timeout_ms;
      endcase
      is_active = (rq.now_ms - last_ff) < limit;

      if (evt_data.cls.is_tick) begin
         unique case (mode_ff)
            MODE_PREP: begin
               if (cfg.stun_enabled && is_active) begin
                  c0 = make_item(ACT_STUN_REQ, ep_none, 1'b0, 1'b0);
                  c0_v = 1'b1;
               end else begin
                  set_req = 1'b1;
                  set_tgt = MODE_FAIL;
               end
            end
            MODE_SYNC: begin
               if (is_active) begin
                  c1 = make_item(ACT_HEARTBEAT, loc_ff, 1'b0, ack_ff);
                  c1_v = loc_ff.valid;
               end else begin
                  set_req = 1'b1;
                  set_tgt = MODE_FAIL;
               end
            end
            MODE_CONN: begin
               if (is_active) begin
                  c0 = make_item(ACT_HEARTBEAT, wide_ff, 1'b0, ack_ff);
                  c0_v = wide_ff.valid;
                  c1 = make_item(ACT_HEARTBEAT, loc_ff, 1'b0, ack_ff);
                  c1_v = loc_ff.valid;
               end else begin
                  set_req = 1'b1;
                  set_tgt = MODE_WAIT;
               end
            end
            MODE_UP: begin
               if (is_active) begin
                  c0 = make_item(ACT_HEARTBEAT, real_ff, 1'b0, ack_ff);
                  c0_v = real_ff.valid;
                  c1 = make_item(ACT_PROBE, real_ff, 1'b0, 1'b0);
                  c1_v = real_ff.valid && cfg.relay_enabled && (phase_ff == 16'd0);
               end else begin
                  set_req = 1'b1;
                  set_tgt = MODE_INIT;
                  c1 = make_item(ACT_ROUTE_RST, ep_none, 1'b0, 1'b0);
                  c1_v = cfg.relay_enabled;
               end
            end
            MODE_WAIT: begin
               if (!is_active) begin
                  set_req = 1'b1;
                  set_tgt = MODE_INIT;
               end
            end
            default: begin
            end
         endcase
         phase_inc = {1'b0, phase_ff} + 17'd1;
         phase_in = (phase_inc >= {1'b0, cfg.probe_period_ticks}) ? 16'd0 : phase_inc[15:0];
      end else if (evt_data.cls.is_connect) begin
         if (mode_ff == MODE_INIT) begin
            set_req = 1'b1;
            set_tgt = MODE_PREP;
         end
      end else if (evt_data.cls.is_report) begin
         if (rq.report_is_local) begin
            loc_in = ep_new;
         end else begin
            wide_in = ep_new;
            if (mode_ff == MODE_SYNC) begin
               set_req = 1'b1;
               set_tgt = MODE_CONN;
            end else if (mode_ff != MODE_UP && mode_ff != MODE_CONN) begin
               set_req = 1'b1;
               set_tgt = MODE_PREP;
               c1 = make_item(ACT_ADDR_REP, ep_none, 1'b1, 1'b0);
               c1_v = 1'b1;
            end
         end
      end else if (evt_data.cls.is_stun) begin
         if (mode_ff == MODE_PREP) begin
            set_req = 1'b1;
            set_tgt = wide_ff.valid ? MODE_CONN : MODE_SYNC;
            c1 = make_item(ACT_ADDR_REP, ep_none, 1'b0, 1'b0);
            c1_v = 1'b1;
         end
      end else if (evt_data.cls.is_heartbeat) begin
         if (mode_ff != MODE_INIT && mode_ff != MODE_WAIT && mode_ff != MODE_FAIL &&
             (!evt_data.priv || !cfg.local_p2p_disabled)) begin
            if (!evt_data.priv) begin
               wide_in = ep_new;
            end else begin
               loc_in = ep_new;
            end
            if (!real_ff.valid || evt_data.priv || !is_private(real_ff.ip)) begin
               real_in = ep_new;
            end
            ack_in = 1'b1;
            if (rq.heartbeat_ack) begin
               set_req = 1'b1;
               set_tgt = MODE_UP;
               c1 = make_item(ACT_PROBE, real_in, 1'b0, 1'b0);
               c1_v = (mode_ff != MODE_UP);
            end
         end
      end

      doubled = {retry_ff, 1'b0};
      if (set_req) begin
         last_in = rq.now_ms;
         if (set_tgt != mode_ff) begin
            if (set_tgt == MODE_INIT || set_tgt == MODE_WAIT || set_tgt == MODE_FAIL) begin
               wide_in = '0;
               loc_in = '0;
               real_in = '0;
               ack_in = 1'b0;
            end
            if (mode_ff == MODE_WAIT && set_tgt == MODE_INIT) begin
               retry_in = (doubled > {1'b0, cfg.retry_max_ms}) ? cfg.retry_max_ms
                                                                : doubled[31:0];
            end else if (set_tgt == MODE_INIT || set_tgt == MODE_FAIL) begin
               retry_in = cfg.retry_min_ms;
            end
            mode_in = set_tgt;
         end
      end

      st = make_item(ACT_STATUS, ep_none, 1'b0, 1'b0);
      st.last = 1'b1;
      c0.link_state = mode_in;
      c1.link_state = mode_in;
      st.link_state = mode_in;
      item_in[0] = c0_v ? c0 : (c1_v ? c1 : st);
      item_in[1] = (c0_v && c1_v) ? c1 : st;
      item_in[2] = st;
      cnt_in = 2'd1 + {1'b0, c0_v} + {1'b0, c1_v};
   end

   assign rsp_empty = (head_ff == cnt_ff);
   assign evt_take = evt_valid && (rsp_empty || (rsp_pop && (head_ff + 2'd1 == cnt_ff)));

   always_comb begin
      case (head_ff)
         2'd0:    rsp_data = item_ff[0];
         2'd1:    rsp_data = item_ff[1];
         default: rsp_data = item_ff[2];
      endcase
      if (evt_take) begin
         head_in = 2'd0;
      end else if (rsp_pop && !rsp_empty) begin
         head_in = head_ff + 2'd1;
      end else begin
         head_in = head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_INIT;
         last_ff  <= 32'd0;
         retry_ff <= RETRY_MIN_RESET;
         phase_ff <= 16'd0;
         wide_ff  <= '0;
         loc_ff   <= '0;
         real_ff  <= '0;
         ack_ff   <= 1'b0;
         head_ff  <= 2'd0;
         cnt_ff   <= 2'd0;
      end else begin
         head_ff <= head_in;
         if (evt_take) begin
            mode_ff  <= mode_in;
            last_ff  <= last_in;
            retry_ff <= retry_in;
            phase_ff <= phase_in;
            wide_ff  <= wide_in;
            loc_ff   <= loc_in;
            real_ff  <= real_in;
            ack_ff   <= ack_in;
            cnt_ff   <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (evt_take) begin
         item_ff[0] <= item_in[0];
         item_ff[1] <= item_in[1];
         item_ff[2] <= item_in[2];
      end
   end

endmodule

// ===== sv/peer_link_connection_fsm_unit.sv =====
// Top level of the peer link connection manager: register file and the
// front/back pair. Depends on plcf_pkg, plcf_front and plcf_back.
//
//   channel   ports                               beat
//   request   req_push, req_full, req_data        one event
//   response  rsp_empty, rsp_pop, rsp_data        one result item
//   csr       csr_we, csr_index, csr_wdata        one register write
//
// The back part handles one event at a time and then drains its one to three
// result beats at one beat per cycle while rsp_pop is held; it takes the next
// event when its last result beat is popped.
// A two-entry event queue lets requests keep arriving while results stall.
// Reset is synchronous and returns the link to INIT with default registers.
module peer_link_connection_fsm_unit import plcf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  req_type              req_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    evt_valid;
   evt_type evt_data;
   logic    evt_take;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_STUN_EN:    cfg_in.stun_enabled = csr_wdata[0];
            CSR_RELAY_EN:   cfg_in.relay_enabled = csr_wdata[0];
            CSR_LOCAL_DIS:  cfg_in.local_p2p_disabled = csr_wdata[0];
            CSR_RETRY_MIN:  cfg_in.retry_min_ms = csr_wdata;
            CSR_RETRY_MAX:  cfg_in.retry_max_ms = csr_wdata;
            CSR_HS_TIMEOUT: cfg_in.handshake_timeout_ms = csr_wdata;
            CSR_ALIVE_TO:   cfg_in.alive_timeout_ms = csr_wdata;
            CSR_PROBE_PER:  cfg_in.probe_period_ticks = csr_wdata[15:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stun_enabled         <= 1'b1;
         cfg_ff.relay_enabled        <= 1'b0;
         cfg_ff.local_p2p_disabled   <= 1'b0;
         cfg_ff.retry_min_ms         <= RETRY_MIN_RESET;
         cfg_ff.retry_max_ms         <= RETRY_MAX_RESET;
         cfg_ff.handshake_timeout_ms <= HS_TIMEOUT_RESET;
         cfg_ff.alive_timeout_ms     <= ALIVE_TO_RESET;
         cfg_ff.probe_period_ticks   <= PROBE_PER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   plcf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .evt_valid (evt_valid),
      .evt_data  (evt_data),
      .evt_take  (evt_take)
   );

   plcf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .evt_valid (evt_valid),
      .evt_data  (evt_data),
      .evt_take  (evt_take),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sv/plcf_checker.sv =====
// Port-level checks for the peer link connection manager and their binding.
// Depends on plcf_pkg and peer_link_connection_fsm_unit.
module plcf_checker import plcf_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);

   a_reset_clears: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.last == (rsp_data.action == ACT_STATUS)))
      else $error("last flag does not match the status beat");

   a_event_unbroken: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_data.last) |=> !rsp_empty)
      else $error("result beats of one event were split");

   a_state_code: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.link_state <= MODE_FAIL))
      else $error("link state out of range");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("stalled result beat changed");

endmodule

bind peer_link_connection_fsm_unit plcf_checker u_plcf_checker (.*);
